### rtl/core/jii_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint impedance integrator package
// Shared types, constants and saturation helpers for the joint impedance
// integrator and its submodules.
// ----------------------------------------------------------------------------
package jii_pkg;

  // Number of joint axes held in the state memories.
  localparam int NUM_AXES = 8;
  // Fraction bits of every fixed-point value.
  localparam int FRAC_BITS = 16;
  // Width of the axis field of an item.
  localparam int AXIS_W = 3;
  // Memory address width that the axis count needs.
  localparam int ADDR_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  // Bits of the squared period after the fraction shift.
  localparam int TT_W = 32 - FRAC_BITS;

  // Sample period after reset.
  localparam logic [15:0] PERIOD_RESET = 16'd66;

  // Opcodes; the result status repeats the opcode.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_HOLD  = 2'd3;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // One input item.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [AXIS_W-1:0]  axis;
    logic signed [31:0] target_pos;
    logic signed [31:0] target_vel;
    logic signed [31:0] ext_torque;
    logic signed [31:0] stiffness_in;
    logic signed [31:0] damping_in;
    logic [30:0]        inv_inertia_in;
    logic signed [31:0] deadband_in;
    logic signed [31:0] measured_pos;
    logic signed [31:0] measured_vel;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [AXIS_W-1:0]  out_axis;
    logic signed [31:0] cmd_pos;
    logic signed [31:0] cmd_vel;
    logic [1:0]         status;
    logic               saturated;
  } out_item_t;

  // Per-axis motion state, one memory word.
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } kin_t;

  // Per-axis gains, one memory word.
  typedef struct packed {
    logic signed [31:0] stiff;
    logic signed [31:0] damp;
    logic [30:0]        inv_inertia;
    logic signed [31:0] deadband;
  } gains_t;

  // Operands handed to the step unit.
  typedef struct packed {
    kin_t               kin;
    gains_t             gains;
    logic signed [31:0] target_pos;
    logic signed [31:0] target_vel;
    logic signed [31:0] torque;
    logic [15:0]        period;
  } step_req_t;

  // Result of the step unit.
  typedef struct packed {
    kin_t kin;
    logic saturated;
  } step_rsp_t;

  // Clip a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // True when a wide signed value lies outside the 32-bit signed range.
  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

endpackage

### rtl/core/jii_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module jii_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/jii_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint impedance step unit
// Runs one integration step in eight phases around a single shared
// multiplier: force, acceleration, then position and velocity.
// ----------------------------------------------------------------------------
module jii_step_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  jii_pkg::step_req_t req,
  output logic               done,
  output jii_pkg::step_rsp_t rsp
);

  localparam logic [2:0] PH_DB  = 3'd0;
  localparam logic [2:0] PH_F1  = 3'd1;
  localparam logic [2:0] PH_F2  = 3'd2;
  localparam logic [2:0] PH_ACC = 3'd3;
  localparam logic [2:0] PH_A   = 3'd4;
  localparam logic [2:0] PH_X1  = 3'd5;
  localparam logic [2:0] PH_X2  = 3'd6;
  localparam logic [2:0] PH_V   = 3'd7;

  localparam int F = jii_pkg::FRAC_BITS;

  jii_pkg::step_req_t req_r;
  jii_pkg::step_rsp_t rsp_r;
  logic                   run_r;
  logic                   done_r;
  logic [2:0]             phase_r;
  logic signed [63:0]     p_r;
  logic signed [63:0]     acc_r;
  logic signed [63:0]     nx_r;
  logic signed [31:0]     a_r;
  logic [jii_pkg::TT_W-1:0] tt_r;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;
  logic signed [32:0] diff_pos;
  logic signed [32:0] diff_vel;
  logic signed [32:0] torque_db;
  logic signed [32:0] db_ext;
  logic signed [32:0] tq_ext;
  logic signed [63:0] nv;

  // Tracking errors and the torque shrunk by the deadband.
  always_comb begin
    diff_pos = 33'(req_r.target_pos) - 33'(req_r.kin.pos);
    diff_vel = 33'(req_r.target_vel) - 33'(req_r.kin.vel);
    db_ext   = 33'(req_r.gains.deadband);
    tq_ext   = 33'(req_r.torque);
    if (tq_ext > db_ext) begin
      torque_db = tq_ext - db_ext;
    end else if (tq_ext < -db_ext) begin
      torque_db = tq_ext + db_ext;
    end else begin
      torque_db = '0;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase_r)
      PH_DB: begin
        mul_a = 34'(req_r.gains.stiff);
        mul_b = 34'(diff_pos);
      end
      PH_F1: begin
        mul_a = 34'(req_r.gains.damp);
        mul_b = 34'(diff_vel);
      end
      PH_F2: begin
        mul_a = $signed({18'b0, req_r.period});
        mul_b = $signed({18'b0, req_r.period});
      end
      PH_ACC: begin
        mul_a = $signed({3'b0, req_r.gains.inv_inertia});
        mul_b = 34'(jii_pkg::sat32(acc_r));
      end
      PH_A: begin
        mul_a = 34'(req_r.kin.vel);
        mul_b = $signed({18'b0, req_r.period});
      end
      PH_X1: begin
        mul_a = 34'(a_r);
        mul_b = $signed({(34 - jii_pkg::TT_W)'(0), tt_r});
      end
      PH_X2: begin
        mul_a = 34'(a_r);
        mul_b = $signed({18'b0, req_r.period});
      end
      PH_V: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign nv   = 64'(req_r.kin.vel) + (p_r >>> F);

  // Phase sequencing and control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_DB;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r   <= 1'b1;
        phase_r <= PH_DB;
      end else if (run_r) begin
        phase_r <= phase_r + 3'd1;
        if (phase_r == PH_V) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: product register, force accumulator and integration.
  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= req;
    end
    if (run_r) begin
      p_r <= prod[63:0];
      unique case (phase_r)
        PH_DB: begin
          acc_r <= 64'(torque_db);
        end
        PH_F1, PH_F2: begin
          acc_r <= acc_r + (p_r >>> F);
        end
        PH_ACC: begin
          tt_r <= p_r[F + jii_pkg::TT_W - 1:F];
        end
        PH_A: begin
          a_r <= jii_pkg::sat32(p_r >>> F);
        end
        PH_X1: begin
          nx_r <= 64'(req_r.kin.pos) + (p_r >>> F);
        end
        PH_X2: begin
          nx_r <= nx_r + (p_r >>> (F + 1));
        end
        PH_V: begin
          rsp_r.kin.pos   <= jii_pkg::sat32(nx_r);
          rsp_r.kin.vel   <= jii_pkg::sat32(nv);
          rsp_r.saturated <= jii_pkg::ovf32(nx_r) | jii_pkg::ovf32(nv);
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign done = done_r;
  assign rsp  = rsp_r;

endmodule

### rtl/core/joint_impedance_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint impedance integrator
// Per-axis impedance model: gains and motion state live in two small RAMs,
// a sequencer reads, updates and writes back one axis per item.
// ----------------------------------------------------------------------------
// The block takes one item at a time and holds in_stall high while an item is
// in work. Load gains, start and hold pass only through the memory read and
// the write back; a step also runs the eight phases of the single shared
// multiplier in the step unit between them. The next item is accepted while a
// finished result still waits in the output register. Reset clears all axis
// state at once through per-axis valid bits, so no clearing pass is needed.
module joint_impedance_integrator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jii_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output jii_pkg::out_item_t  out_item,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int KIN_W  = $bits(jii_pkg::kin_t);
  localparam int GAIN_W = $bits(jii_pkg::gains_t);

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  logic [15:0]                  period_r;
  jii_pkg::in_item_t            item_r;
  logic [jii_pkg::NUM_AXES-1:0] kin_vld_r;
  logic [jii_pkg::NUM_AXES-1:0] gain_vld_r;
  logic                         kin_ok_r;
  logic                         gain_ok_r;
  jii_pkg::kin_t                res_r;
  logic                         res_sat_r;
  logic                         out_valid_r;
  jii_pkg::out_item_t           out_item_r;

  logic                         in_acc;
  logic                         out_free;
  logic                         ax_ok;
  logic [jii_pkg::ADDR_W-1:0]   rd_addr;
  logic [jii_pkg::ADDR_W-1:0]   wr_addr;
  logic [KIN_W-1:0]             kin_rdata;
  logic [GAIN_W-1:0]            gain_rdata;
  jii_pkg::kin_t                kin_cur;
  jii_pkg::gains_t              gain_cur;
  jii_pkg::gains_t              gain_wdata;
  logic                         kin_we;
  logic                         gain_we;
  logic [34:0]                  ii_x10;
  logic                         step_start;
  logic                         step_done;
  jii_pkg::step_req_t           step_req;
  jii_pkg::step_rsp_t           step_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_addr  = jii_pkg::ADDR_W'(in_item.axis);
  assign wr_addr  = jii_pkg::ADDR_W'(item_r.axis);
  assign ax_ok    = (32'(item_r.axis) < 32'(jii_pkg::NUM_AXES));

  // Entries never written since reset read as zero.
  assign kin_cur  = kin_ok_r  ? jii_pkg::kin_t'(kin_rdata)    : '0;
  assign gain_cur = gain_ok_r ? jii_pkg::gains_t'(gain_rdata) : '0;

  // Gain clamping on load: default damping is ten times the inverse inertia.
  always_comb begin
    ii_x10 = {item_r.inv_inertia_in, 3'b0} + {2'b0, item_r.inv_inertia_in, 1'b0};
    gain_wdata.stiff       = (item_r.stiffness_in < 0) ? '0 : item_r.stiffness_in;
    gain_wdata.inv_inertia = item_r.inv_inertia_in;
    gain_wdata.deadband    = (item_r.deadband_in <= 0) ? '0 : item_r.deadband_in;
    if (item_r.damping_in > 0) begin
      gain_wdata.damp = item_r.damping_in;
    end else if (ii_x10 > 35'h07FFFFFFF) begin
      gain_wdata.damp = 32'sh7FFFFFFF;
    end else begin
      gain_wdata.damp = $signed(ii_x10[31:0]);
    end
  end

  // Write back in the final state, once the output register can take the item.
  assign kin_we  = (state_r == ST_DONE) && out_free && ax_ok &&
                   ((item_r.opcode == jii_pkg::OP_START) ||
                    (item_r.opcode == jii_pkg::OP_STEP));
  assign gain_we = (state_r == ST_DONE) && out_free && ax_ok &&
                   (item_r.opcode == jii_pkg::OP_LOAD);

  jii_ram #(
    .WIDTH (KIN_W),
    .DEPTH (jii_pkg::NUM_AXES)
  ) u_kin_ram (
    .clk     (clk),
    .wr_en   (kin_we),
    .wr_addr (wr_addr),
    .wr_data (res_r),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (kin_rdata)
  );

  jii_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (jii_pkg::NUM_AXES)
  ) u_gain_ram (
    .clk     (clk),
    .wr_en   (gain_we),
    .wr_addr (wr_addr),
    .wr_data (gain_wdata),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (gain_rdata)
  );

  // Step operands: memory read data, item fields and the period register.
  always_comb begin
    step_req.kin        = kin_cur;
    step_req.gains      = gain_cur;
    step_req.target_pos = item_r.target_pos;
    step_req.target_vel = item_r.target_vel;
    step_req.torque     = item_r.ext_torque;
    step_req.period     = period_r;
  end

  assign step_start = (state_r == ST_READ) && ax_ok && (item_r.opcode == jii_pkg::OP_STEP);

  jii_step_unit u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_start),
    .req   (step_req),
    .done  (step_done),
    .rsp   (step_rsp)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = step_start ? ST_STEP : ST_DONE;
      end
      ST_STEP: begin
        if (step_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers: state, period, valid bits, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= jii_pkg::PERIOD_RESET;
      kin_vld_r   <= '0;
      gain_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (kin_we) begin
        kin_vld_r[wr_addr] <= 1'b1;
      end
      if (gain_we) begin
        gain_vld_r[wr_addr] <= 1'b1;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item capture, per-opcode result and output register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r    <= in_item;
      kin_ok_r  <= kin_vld_r[rd_addr];
      gain_ok_r <= gain_vld_r[rd_addr];
    end
    if (state_r == ST_READ) begin
      res_sat_r <= 1'b0;
      if (!ax_ok) begin
        res_r <= '0;
      end else if (item_r.opcode == jii_pkg::OP_START) begin
        res_r.pos <= item_r.measured_pos;
        res_r.vel <= item_r.measured_vel;
      end else begin
        res_r <= kin_cur;
      end
    end
    if ((state_r == ST_STEP) && step_done) begin
      res_r     <= step_rsp.kin;
      res_sat_r <= step_rsp.saturated;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_item_r.out_axis  <= item_r.axis;
      out_item_r.cmd_pos   <= res_r.pos;
      out_item_r.cmd_vel   <= res_r.vel;
      out_item_r.status    <= item_r.opcode;
      out_item_r.saturated <= res_sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/core/jii_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint impedance integrator port checker
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module jii_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input jii_pkg::out_item_t out_item
);

  // A stalled result item stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or was dropped");

  // Only a step can report saturation.
  a_sat_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.saturated || out_item.status == jii_pkg::OP_STEP))
    else $error("saturation flagged on a non-step item");

  // One item at a time: an accepted item blocks the input in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again while an item is in work");

  // A new result only appears while an item was in work.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared without an item in work");

endmodule

bind joint_impedance_integrator jii_checker u_jii_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### tb/joint_motion_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint motion checker
// Watches the item channel, the result channel and the period register of the
// joint impedance integrator. Each accepted item is run through a per-axis
// fixed-point model of its own, and the results that the block returns are
// compared in order against the predicted ones.
// ----------------------------------------------------------------------------
module joint_motion_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  jii_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  jii_pkg::out_item_t  out_item,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output int                  pending,
  output int                  errors,
  output int                  checked,
  output int                  clipped
);
  import jii_pkg::*;

  localparam int     REPORT_LIMIT = 10;
  localparam int     DAMP_SCALE   = 10;
  localparam longint WORD_MAX     = 64'sd2147483647;
  localparam longint WORD_MIN     = -64'sd2147483648;

  // Model copy of the per-axis state and of the period register.
  logic signed [31:0] pos_q      [NUM_AXES];
  logic signed [31:0] vel_q      [NUM_AXES];
  logic signed [31:0] stiff_q    [NUM_AXES];
  logic signed [31:0] damp_q     [NUM_AXES];
  logic [30:0]        inv_mass_q [NUM_AXES];
  logic signed [31:0] deadband_q [NUM_AXES];
  logic [15:0]        period_q;

  // Results predicted for accepted items, oldest first.
  out_item_t expected_motion[$];

  int fail_cnt  = 0;
  int check_cnt = 0;
  int clip_cnt  = 0;

  function automatic logic word_overflows(input longint v);
    return (v > WORD_MAX) || (v < WORD_MIN);
  endfunction

  function automatic logic signed [31:0] clip_word(input longint v);
    if (v > WORD_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < WORD_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Applies one item to the model state and returns the result it causes.
  function automatic out_item_t advance_axis(input in_item_t it);
    out_item_t r;
    longint    x, v, k, d, ii, db, t, per, tt, f, a, nx, nv, tpos, tvel;
    logic      clip;
    int        ax;
    ax   = it.axis;
    clip = 1'b0;
    case (it.opcode)
      OP_LOAD: begin
        k  = $signed(it.stiffness_in);
        d  = $signed(it.damping_in);
        ii = it.inv_inertia_in;
        db = $signed(it.deadband_in);
        stiff_q[ax]    = (k < 0) ? 32'sd0 : it.stiffness_in;
        inv_mass_q[ax] = it.inv_inertia_in;
        damp_q[ax]     = (d <= 0) ? clip_word(ii * DAMP_SCALE) : it.damping_in;
        deadband_q[ax] = (db <= 0) ? 32'sd0 : it.deadband_in;
      end
      OP_START: begin
        pos_q[ax] = it.measured_pos;
        vel_q[ax] = it.measured_vel;
      end
      OP_STEP: begin
        x    = pos_q[ax];
        v    = vel_q[ax];
        k    = stiff_q[ax];
        d    = damp_q[ax];
        ii   = inv_mass_q[ax];
        db   = deadband_q[ax];
        per  = period_q;
        t    = $signed(it.ext_torque);
        tpos = $signed(it.target_pos);
        tvel = $signed(it.target_vel);
        // Torque inside the deadband is dropped, outside it is pulled in.
        if (t > db) begin
          t = t - db;
        end else if (t < -db) begin
          t = t + db;
        end else begin
          t = 0;
        end
        // Spring and damper force plus torque, then acceleration.
        f  = ((k * (tpos - x)) >>> FRAC_BITS) + ((d * (tvel - v)) >>> FRAC_BITS) + t;
        f  = clip_word(f);
        a  = clip_word((ii * f) >>> FRAC_BITS);
        // One period of integration; position uses the old velocity.
        tt = (per * per) >>> FRAC_BITS;
        nx = x + ((v * per) >>> FRAC_BITS) + ((a * tt) >>> (FRAC_BITS + 1));
        nv = v + ((a * per) >>> FRAC_BITS);
        clip      = word_overflows(nx) || word_overflows(nv);
        pos_q[ax] = clip_word(nx);
        vel_q[ax] = clip_word(nv);
      end
      default: begin
      end
    endcase
    r.out_axis  = it.axis;
    r.cmd_pos   = pos_q[ax];
    r.cmd_vel   = vel_q[ax];
    r.status    = it.opcode;
    r.saturated = clip;
    return r;
  endfunction

  // Compares one returned result with the oldest prediction.
  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (expected_motion.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_LIMIT) begin
        $display("[%0t] result with no item pending: axis %0d pos %0d vel %0d status %0d sat %0d",
                 $time, got.out_axis, $signed(got.cmd_pos), $signed(got.cmd_vel),
                 got.status, got.saturated);
      end
    end else begin
      want = expected_motion.pop_front();
      check_cnt++;
      if (want.saturated) begin
        clip_cnt++;
      end
      if (got.out_axis !== want.out_axis || got.cmd_pos !== want.cmd_pos ||
          got.cmd_vel !== want.cmd_vel || got.status !== want.status ||
          got.saturated !== want.saturated) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
          $display("[%0t] result %0d expected axis %0d pos %0d vel %0d status %0d sat %0d",
                   $time, check_cnt, want.out_axis, $signed(want.cmd_pos),
                   $signed(want.cmd_vel), want.status, want.saturated);
          $display("[%0t] result %0d actual   axis %0d pos %0d vel %0d status %0d sat %0d",
                   $time, check_cnt, got.out_axis, $signed(got.cmd_pos),
                   $signed(got.cmd_vel), got.status, got.saturated);
        end
      end
    end
  endtask

  // Channel monitor: results are matched before new items are predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_q[i]      = '0;
        vel_q[i]      = '0;
        stiff_q[i]    = '0;
        damp_q[i]     = '0;
        inv_mass_q[i] = '0;
        deadband_q[i] = '0;
      end
      period_q = PERIOD_RESET;
      expected_motion.delete();
    end else begin
      if (cfg_wr_en) begin
        period_q = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        compare_result(out_item);
      end
      if (in_valid && !in_stall) begin
        expected_motion = {expected_motion, advance_axis(in_item)};
      end
    end
    pending <= expected_motion.size();
    errors  <= fail_cnt;
    checked <= check_cnt;
    clipped <= clip_cnt;
  end

endmodule

### tb/tb_joint_impedance_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint impedance integrator testbench
// Drives directed and random axis items through the integrator under several
// sample periods, with random gaps and stalls on both channels and one long
// output hold-off. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_joint_impedance_integrator;
  import jii_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int RUN_LIMIT_NS = 5_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int pending;
  int errors;
  int checked;
  int clipped;

  // Traffic shaping shared by the sender and the receiver.
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;
  bit hold_request = 1'b0;
  int op_count[4]  = '{0, 0, 0, 0};
  int settings_used = 1;

  joint_impedance_integrator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  joint_motion_checker u_motion_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .errors      (errors),
    .checked     (checked),
    .clipped     (clipped)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Word mix: the two extremes, small values around zero, and raw bits.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  // Item with every field filled at random.
  function automatic in_item_t noise_item();
    in_item_t    it;
    logic [31:0] w;
    it.opcode       = 2'($urandom_range(0, 3));
    it.axis         = AXIS_W'($urandom_range(0, NUM_AXES - 1));
    it.target_pos   = rand_word();
    it.target_vel   = rand_word();
    it.ext_torque   = rand_word();
    it.stiffness_in = rand_word();
    it.damping_in   = rand_word();
    w               = rand_word();
    it.inv_inertia_in = w[30:0];
    it.deadband_in  = rand_word();
    it.measured_pos = rand_word();
    it.measured_vel = rand_word();
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [2:0] ax, input logic [31:0] k,
                                         input logic [31:0] d, input logic [31:0] ii,
                                         input logic [31:0] db);
    in_item_t it;
    it = noise_item();
    it.opcode         = OP_LOAD;
    it.axis           = ax;
    it.stiffness_in   = k;
    it.damping_in     = d;
    it.inv_inertia_in = ii[30:0];
    it.deadband_in    = db;
    return it;
  endfunction

  function automatic in_item_t start_item(input logic [2:0] ax, input logic [31:0] p,
                                          input logic [31:0] v);
    in_item_t it;
    it = noise_item();
    it.opcode       = OP_START;
    it.axis         = ax;
    it.measured_pos = p;
    it.measured_vel = v;
    return it;
  endfunction

  function automatic in_item_t step_item(input logic [2:0] ax, input logic [31:0] tp,
                                         input logic [31:0] tv, input logic [31:0] tq);
    in_item_t it;
    it = noise_item();
    it.opcode     = OP_STEP;
    it.axis       = ax;
    it.target_pos = tp;
    it.target_vel = tv;
    it.ext_torque = tq;
    return it;
  endfunction

  function automatic in_item_t hold_item(input logic [2:0] ax);
    in_item_t it;
    it = noise_item();
    it.opcode = OP_HOLD;
    it.axis   = ax;
    return it;
  endfunction

  // Mostly servo-like traffic in the working range, a quarter left as noise.
  function automatic in_item_t servo_item();
    in_item_t it;
    int       pick;
    it   = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      it.opcode = OP_LOAD;
    end else if (pick < 24) begin
      it.opcode = OP_START;
    end else if (pick < 82) begin
      it.opcode = OP_STEP;
    end else begin
      it.opcode = OP_HOLD;
    end
    if ($urandom_range(0, 3) != 0) begin
      it.stiffness_in   = $urandom_range(0, 32'h0008_0000);
      it.damping_in     = $urandom_range(0, 32'h0004_8000) - 32'h0000_8000;
      it.inv_inertia_in = 31'($urandom_range(0, 32'h0002_0000));
      it.deadband_in    = $urandom_range(0, 32'h0002_0000) - 32'h0000_4000;
      it.measured_pos   = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      it.measured_vel   = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      it.target_pos     = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      it.target_vel     = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      it.ext_torque     = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    end
    return it;
  endfunction

  // Offers one item after a random gap and returns at the edge that takes it.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    op_count[it.opcode]++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_servo(input int count);
    repeat (count) send_item(servo_item());
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // Result receiver: a random stall per item, or one long hold-off on request.
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold         = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, 13);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Steps before any gains: the axis only integrates its velocity.
    send_item(step_item(3'd0, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    send_item(start_item(3'd1, 32'h0001_0000, 32'h0004_0000));
    send_item(step_item(3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(hold_item(3'd1));

    // Gain clamping: negative stiffness, zero and negative damping, negative
    // and zero deadband, damping default that overflows, zero inverse inertia.
    send_item(load_item(3'd2, 32'hFFFB_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF));
    send_item(load_item(3'd3, 32'h0010_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0000));
    send_item(load_item(3'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF));
    send_item(load_item(3'd5, 32'h0004_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000));
    send_item(load_item(3'd6, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));

    // Torque inside, above and below the deadband.
    send_item(start_item(3'd5, 32'h0000_0000, 32'h0000_0000));
    send_item(step_item(3'd5, 32'h000A_0000, 32'h0000_0000, 32'h0000_8000));
    send_item(step_item(3'd5, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000));
    send_item(step_item(3'd5, 32'h0000_0000, 32'h0000_0000, 32'hFFFD_0000));

    // Axis with zero inverse inertia moves on its velocity alone.
    send_item(start_item(3'd4, 32'h0000_0100, 32'h0000_0200));
    send_item(step_item(3'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));

    // Clipping at the top and the bottom of the range.
    send_item(start_item(3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(step_item(3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(start_item(3'd2, 32'h8000_0000, 32'h8000_0000));
    send_item(step_item(3'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(start_item(3'd6, 32'h0000_0000, 32'h7FFF_FFFF));
    send_item(step_item(3'd6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_item(hold_item(3'd3));
    send_item(step_item(3'd7, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_item(hold_item(3'd7));

    // Random servo traffic at the reset period.
    send_servo(200);

    // Longest period, with no idling on either side.
    write_period(16'hFFFF);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_servo(100);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Zero period: steps move nothing and never clip, so they echo the state.
    write_period(16'h0000);
    send_servo(80);

    write_period(16'h0001);
    send_servo(60);

    // Back-pressure: the receiver holds off while items keep coming.
    write_period(16'd655);
    hold_request = 1'b1;
    tx_quiet     = 1'b1;
    send_servo(40);
    tx_quiet     = 1'b0;
    drain_block();

    write_period(16'($urandom_range(0, 16'hFFFF)));
    send_servo(150);

    write_period(16'd6554);
    rx_quiet = 1'b1;
    send_servo(100);
    rx_quiet = 1'b0;

    drain_block();
    $display("Drove %0d items (%0d load, %0d start, %0d step, %0d hold) over %0d period settings.",
             op_count[OP_LOAD] + op_count[OP_START] + op_count[OP_STEP] + op_count[OP_HOLD],
             op_count[OP_LOAD], op_count[OP_START], op_count[OP_STEP], op_count[OP_HOLD],
             settings_used);
    $display("Compared %0d results, %0d of them clipped, with a %0d-cycle output hold-off.",
             checked, clipped, LONG_HOLD);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results outstanding.", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
